// ----- rtl/core/point_in_polygon_ray_cast_defines.svh -----
// assertion macros for the point-in-polygon ray casting block
// no dependencies; taken in by the rtl files that carry assertions
`ifndef POINT_IN_POLYGON_RAY_CAST_DEFINES_SVH
`define POINT_IN_POLYGON_RAY_CAST_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PIP_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PIP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pipray_pkg.sv -----
// shared types and constants of the point-in-polygon ray casting block
// no dependencies
package pipray_pkg;

  // register index of the far ray end
  localparam int REG_RAY_END_X = 0;
  localparam longint RAY_END_DEFAULT = 64'sd655360000;

  // edge slots per vertex: edge from the previous vertex, closing edge
  localparam int NUM_EDGES  = 2;
  localparam int EDGE_OPEN  = 0;
  localparam int EDGE_CLOSE = 1;

  // products per edge
  localparam int NUM_MULS = 3;
  localparam int MUL_PB   = 0;  // dy * (px - bx)
  localparam int MUL_DW   = 1;  // dx * (py - by)
  localparam int MUL_EB   = 2;  // dy * (ex - bx)

  typedef enum logic [1:0] {
    ORI_COL = 2'd0,
    ORI_CW  = 2'd1,
    ORI_CCW = 2'd2
  } orient_e;

  typedef struct packed {
    logic       first_vtx;
    logic       emit;
    logic [1:0] test_edge;
  } item_ctrl_t;

  typedef struct packed {
    logic ray_split;
    logic ray_touch;
    logic p_in_ab;
    logic e_in_ab;
  } edge_flags_t;

  typedef struct packed {
    logic hit;
    logic coll;
    logic on_edge;
  } edge_res_t;

endpackage

// ----- rtl/core/pipray_if.sv -----
// valid/ready channel interfaces for vertex items and inside results
// no dependencies
interface pipray_vert_if #(
  parameter int COORD_BITS = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vert_x;
  logic signed [COORD_BITS-1:0] vert_y;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic                         last_vertex;

  modport source (output valid, vert_x, vert_y, query_x, query_y, last_vertex, input ready);
  modport sink (input valid, vert_x, vert_y, query_x, query_y, last_vertex, output ready);
endinterface

interface pipray_res_if ();
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

// ----- rtl/core/point_in_polygon_ray_cast.sv -----
// point-in-polygon test by ray casting, one vertex per transfer
// depends on pipray_pkg, pipray_if.sv and point_in_polygon_ray_cast_defines.svh
//
// usage
//   vert_i carries one polygon vertex per transfer. the first transfer of a
//   polygon also carries the query point, which is held for the whole
//   polygon; last_vertex marks the final vertex. on that transfer one
//   inside_res transfer follows on res_o (1 = inside or on the boundary,
//   0 for fewer than three vertices). other vertices give no result.
//   the far x of the ray is written over the apb-style port at address 0
//   while no polygon is in flight.
// timing
//   one vertex per cycle sustained while res_o takes results. the result of
//   a last vertex reaches res_o through these registers: partial products,
//   product assembly, orientation and edge decode and the result register
//   follow the input register. the split of each exact product into four
//   half-width partials sets the depth of the pipe.
// reset
//   asynchronous, active low. empties the pipe, clears the vertex count and
//   crossing state and loads the far ray x with 10000.0 (saturated when the
//   coordinates are narrower).
// stalls
//   a result waiting on res_o only stops the pipe once a further result
//   reaches the last stage; until then vertices keep flowing into bubbles.
`include "point_in_polygon_ray_cast_defines.svh"

module point_in_polygon_ray_cast
  import pipray_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  pipray_vert_if.sink                                vert_i,
  pipray_res_if.source                               res_o,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [((COORD_BITS > 32) ? 3 : 2)-1:0]     paddr,
  input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0]   pwdata,
  output logic [((COORD_BITS > 32) ? 64 : 32)-1:0]   prdata,
  output logic                                       pready
);

  localparam int PDW = (COORD_BITS > 32) ? 64 : 32;
  localparam int PAW = (COORD_BITS > 32) ? 3 : 2;
  localparam int OW  = COORD_BITS + 1;
  localparam int LW  = OW / 2;
  localparam int HW  = OW - LW;
  localparam int PW  = 2 * OW;
  localparam int CW  = PW + 1;

  localparam logic [PAW-1:0] RayEndAddr = PAW'(REG_RAY_END_X * (PDW / 8));
  localparam logic [COORD_BITS-1:0] RayEndRst = (COORD_BITS >= 31) ?
      COORD_BITS'(RAY_END_DEFAULT) : {1'b0, {(COORD_BITS-1){1'b1}}};

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OW-1:0]         diff_t;

  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t px_bx;
    diff_t py_by;
    diff_t ex_bx;
  } edge_ops_t;

  function automatic logic between(coord_t v, coord_t a, coord_t b);
    return (a <= b) ? (v >= a && v <= b) : (v >= b && v <= a);
  endfunction

  // orientation against the horizontal ray, sign of -(ex - px) * (y - py)
  function automatic orient_e ray_orient(coord_t ex, coord_t px, coord_t y, coord_t py);
    if (ex == px || y == py) return ORI_COL;
    return ((ex > px) == (y > py)) ? ORI_CCW : ORI_CW;
  endfunction

  function automatic orient_e cross_orient(logic signed [CW-1:0] c);
    if (c == '0) return ORI_COL;
    return c[CW-1] ? ORI_CCW : ORI_CW;
  endfunction

  // configuration
  coord_t ray_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_end_q <= coord_t'(RayEndRst);
    end else if (psel && penable && pwrite && paddr == RayEndAddr) begin
      ray_end_q <= coord_t'(pwdata[COORD_BITS-1:0]);
    end
  end

  assign prdata = (paddr == RayEndAddr) ? PDW'(ray_end_q) : '0;
  assign pready = 1'b1;

  // pipe control
  logic in_fire, out_free;
  logic s1_take, s2_take, s3_take, s4_take, s4_fire;
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  item_ctrl_t s1_ctrl_q, s2_ctrl_q, s3_ctrl_q, s4_ctrl_q;
  logic out_valid_q, inside_q;

  assign out_free = !out_valid_q || res_o.ready;
  assign s4_fire  = s4_valid_q && (!s4_ctrl_q.emit || out_free);
  assign s4_take  = !s4_valid_q || s4_fire;
  assign s3_take  = !s3_valid_q || s4_take;
  assign s2_take  = !s2_valid_q || s3_take;
  assign s1_take  = !s1_valid_q || s2_take;
  assign vert_i.ready = s1_take;
  assign in_fire  = vert_i.valid && s1_take;

  // polygon walk state
  logic [1:0] seen_q;
  coord_t first_x_q, first_y_q, prev_x_q, prev_y_q, held_x_q, held_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 2'd0;
    end else if (in_fire) begin
      if (vert_i.last_vertex) begin
        seen_q <= 2'd0;
      end else if (seen_q != 2'd3) begin
        seen_q <= seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prev_x_q <= vert_i.vert_x;
      prev_y_q <= vert_i.vert_y;
      if (seen_q == 2'd0) begin
        first_x_q <= vert_i.vert_x;
        first_y_q <= vert_i.vert_y;
        held_x_q  <= vert_i.query_x;
        held_y_q  <= vert_i.query_y;
      end
    end
  end

  // stage 1: edge operands and ray-side flags
  item_ctrl_t  ctrl_d;
  edge_ops_t   ops_d   [NUM_EDGES];
  edge_flags_t flags_d [NUM_EDGES];
  edge_ops_t   s1_ops_q   [NUM_EDGES];
  edge_flags_t s1_flags_q [NUM_EDGES];
  edge_flags_t s2_flags_q [NUM_EDGES];
  edge_flags_t s3_flags_q [NUM_EDGES];

  assign ctrl_d = '{
    first_vtx: seen_q == 2'd0,
    emit:      vert_i.last_vertex,
    test_edge: {vert_i.last_vertex && seen_q >= 2'd2, seen_q != 2'd0}
  };

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge_in
    coord_t ax, ay, bx, by;
    if (e == EDGE_OPEN) begin : g_open
      assign ax = prev_x_q;
      assign ay = prev_y_q;
      assign bx = vert_i.vert_x;
      assign by = vert_i.vert_y;
    end else begin : g_close
      assign ax = vert_i.vert_x;
      assign ay = vert_i.vert_y;
      assign bx = first_x_q;
      assign by = first_y_q;
    end

    assign ops_d[e] = '{
      dx:    diff_t'(bx) - diff_t'(ax),
      dy:    diff_t'(by) - diff_t'(ay),
      px_bx: diff_t'(held_x_q) - diff_t'(bx),
      py_by: diff_t'(held_y_q) - diff_t'(by),
      ex_bx: diff_t'(ray_end_q) - diff_t'(bx)
    };

    assign flags_d[e] = '{
      ray_split: ray_orient(ray_end_q, held_x_q, ay, held_y_q) !=
                 ray_orient(ray_end_q, held_x_q, by, held_y_q),
      ray_touch: (ay == held_y_q && between(ax, held_x_q, ray_end_q)) ||
                 (by == held_y_q && between(bx, held_x_q, ray_end_q)),
      p_in_ab:   between(held_x_q, ax, bx) && between(held_y_q, ay, by),
      e_in_ab:   between(ray_end_q, ax, bx) && between(held_y_q, ay, by)
    };
  end

  // stage 2: half-width partial products
  logic signed [2*HW-1:0]  hh_d [NUM_EDGES][NUM_MULS];
  logic signed [HW+LW:0]   hl_d [NUM_EDGES][NUM_MULS];
  logic signed [HW+LW:0]   lh_d [NUM_EDGES][NUM_MULS];
  logic        [2*LW-1:0]  ll_d [NUM_EDGES][NUM_MULS];
  logic signed [2*HW-1:0]  s2_hh_q [NUM_EDGES][NUM_MULS];
  logic signed [HW+LW:0]   s2_hl_q [NUM_EDGES][NUM_MULS];
  logic signed [HW+LW:0]   s2_lh_q [NUM_EDGES][NUM_MULS];
  logic        [2*LW-1:0]  s2_ll_q [NUM_EDGES][NUM_MULS];

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge_mul
    for (genvar k = 0; k < NUM_MULS; k++) begin : g_mul
      diff_t a, b;
      logic signed [HW-1:0] ah, bh;
      logic [LW-1:0] al, bl;
      if (k == MUL_PB) begin : g_pb
        assign a = s1_ops_q[e].dy;
        assign b = s1_ops_q[e].px_bx;
      end else if (k == MUL_DW) begin : g_dw
        assign a = s1_ops_q[e].dx;
        assign b = s1_ops_q[e].py_by;
      end else begin : g_eb
        assign a = s1_ops_q[e].dy;
        assign b = s1_ops_q[e].ex_bx;
      end
      assign ah = $signed(a[OW-1:LW]);
      assign bh = $signed(b[OW-1:LW]);
      assign al = a[LW-1:0];
      assign bl = b[LW-1:0];
      assign hh_d[e][k] = ah * bh;
      assign hl_d[e][k] = ah * $signed({1'b0, bl});
      assign lh_d[e][k] = $signed({1'b0, al}) * bh;
      assign ll_d[e][k] = al * bl;
    end
  end

  // stage 3: exact products
  logic signed [PW-1:0] prod_d    [NUM_EDGES][NUM_MULS];
  logic signed [PW-1:0] s3_prod_q [NUM_EDGES][NUM_MULS];

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge_sum
    for (genvar k = 0; k < NUM_MULS; k++) begin : g_sum
      assign prod_d[e][k] = (PW'(s2_hh_q[e][k]) <<< (2 * LW)) +
                            (PW'(s2_hl_q[e][k]) <<< LW) +
                            (PW'(s2_lh_q[e][k]) <<< LW) +
                            PW'(s2_ll_q[e][k]);
    end
  end

  // stage 4: orientations and edge outcome
  edge_res_t res_d    [NUM_EDGES];
  edge_res_t s4_res_q [NUM_EDGES];

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge_dec
    logic signed [CW-1:0] cross_p, cross_e;
    orient_e o_p, o_e;
    assign cross_p = CW'(s3_prod_q[e][MUL_PB]) - CW'(s3_prod_q[e][MUL_DW]);
    assign cross_e = CW'(s3_prod_q[e][MUL_EB]) - CW'(s3_prod_q[e][MUL_DW]);
    assign o_p = cross_orient(cross_p);
    assign o_e = cross_orient(cross_e);
    assign res_d[e] = '{
      hit:     (o_p != o_e && s3_flags_q[e].ray_split) || s3_flags_q[e].ray_touch ||
               (o_p == ORI_COL && s3_flags_q[e].p_in_ab) ||
               (o_e == ORI_COL && s3_flags_q[e].e_in_ab),
      coll:    o_p == ORI_COL,
      on_edge: s3_flags_q[e].p_in_ab
    };
  end

  // pipe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s1_ctrl_q  <= '0;
      s2_ctrl_q  <= '0;
      s3_ctrl_q  <= '0;
      s4_ctrl_q  <= '0;
    end else begin
      if (s1_take) begin
        s1_valid_q <= vert_i.valid;
        s1_ctrl_q  <= ctrl_d;
      end
      if (s2_take) begin
        s2_valid_q <= s1_valid_q;
        s2_ctrl_q  <= s1_ctrl_q;
      end
      if (s3_take) begin
        s3_valid_q <= s2_valid_q;
        s3_ctrl_q  <= s2_ctrl_q;
      end
      if (s4_take) begin
        s4_valid_q <= s3_valid_q;
        s4_ctrl_q  <= s3_ctrl_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      if (s1_take) begin
        s1_ops_q[e]   <= ops_d[e];
        s1_flags_q[e] <= flags_d[e];
      end
      if (s2_take) begin
        s2_flags_q[e] <= s1_flags_q[e];
        for (int k = 0; k < NUM_MULS; k++) begin
          s2_hh_q[e][k] <= hh_d[e][k];
          s2_hl_q[e][k] <= hl_d[e][k];
          s2_lh_q[e][k] <= lh_d[e][k];
          s2_ll_q[e][k] <= ll_d[e][k];
        end
      end
      if (s3_take) begin
        s3_flags_q[e] <= s2_flags_q[e];
        for (int k = 0; k < NUM_MULS; k++) begin
          s3_prod_q[e][k] <= prod_d[e][k];
        end
      end
      if (s4_take) begin
        s4_res_q[e] <= res_d[e];
      end
    end
  end

  // crossing parity and collinear decision
  logic crossing_parity_q, answer_fixed_q, fixed_value_q;
  logic parity_d, fixed_d, value_d, inside_d;

  always_comb begin
    parity_d = s4_ctrl_q.first_vtx ? 1'b0 : crossing_parity_q;
    fixed_d  = s4_ctrl_q.first_vtx ? 1'b0 : answer_fixed_q;
    value_d  = s4_ctrl_q.first_vtx ? 1'b0 : fixed_value_q;
    for (int e = 0; e < NUM_EDGES; e++) begin
      if (s4_ctrl_q.test_edge[e] && !fixed_d && s4_res_q[e].hit) begin
        if (s4_res_q[e].coll) begin
          fixed_d = 1'b1;
          value_d = s4_res_q[e].on_edge;
        end else begin
          parity_d = !parity_d;
        end
      end
    end
    inside_d = s4_ctrl_q.test_edge[EDGE_CLOSE] && (fixed_d ? value_d : parity_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crossing_parity_q <= 1'b0;
      answer_fixed_q    <= 1'b0;
      fixed_value_q     <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      if (s4_fire) begin
        crossing_parity_q <= parity_d && !s4_ctrl_q.emit;
        answer_fixed_q    <= fixed_d && !s4_ctrl_q.emit;
        fixed_value_q     <= value_d && !s4_ctrl_q.emit;
      end
      if (s4_fire && s4_ctrl_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_fire && s4_ctrl_q.emit) begin
      inside_q <= inside_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.inside_res = inside_q;

  `PIP_ASSERT_NEXT(a_seen_clear, clk_i, rst_ni, in_fire && vert_i.last_vertex, seen_q == 2'd0, "vertex count not cleared after last vertex")
  `PIP_ASSERT_IMPL(a_close_on_emit, clk_i, rst_ni, s4_valid_q && s4_ctrl_q.test_edge[EDGE_CLOSE], s4_ctrl_q.emit, "closing edge tested on a non-final vertex")
  `PIP_ASSERT_IMPL(a_first_no_edge, clk_i, rst_ni, s4_valid_q && s4_ctrl_q.first_vtx, s4_ctrl_q.test_edge == 2'b00, "edge tested on the first vertex")
  `PIP_ASSERT_NEXT(a_state_clear, clk_i, rst_ni, s4_fire && s4_ctrl_q.emit, !crossing_parity_q && !answer_fixed_q && !fixed_value_q, "crossing state not cleared after result")

endmodule
